@@ rtl/slrc_pkg.sv @@
// Shared types and constants for the stepped line rectangle clipper.
`timescale 1ns / 1ps
`default_nettype none
package slrc_pkg;

	localparam int COORD_W   = 32;           // 16.16 coordinate width
	localparam int CNT_W     = 16;           // step count and step index width
	localparam int NUM_W     = COORD_W + 2;  // divider numerator, signed
	localparam int PROD_W    = COORD_W + CNT_W + 1;
	localparam int J_W       = CNT_W + 2;    // signed step index with headroom
	localparam int CFG_IDX_W = 4;
	localparam int DIV_LAT   = 2 + CNT_W / 2;
	localparam int VIS_LAT   = 4;

	localparam logic [CFG_IDX_W-1:0] REG_X_MIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_X_MAX = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = CFG_IDX_W'(3);

	typedef struct packed {
		logic signed [COORD_W-1:0] x_min;
		logic signed [COORD_W-1:0] y_min;
		logic signed [COORD_W-1:0] x_max;
		logic signed [COORD_W-1:0] y_max;
	} rect_t;

endpackage
`default_nettype wire

@@ rtl/slrc_div.sv @@
// Pipelined floor division, quotient clamped to -1 .. 2^CNT_W-1, two bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module slrc_div
	import slrc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic signed [NUM_W-1:0]  num,
	input  wire logic [COORD_W-1:0]       den,
	output logic signed [CNT_W:0]         quot
);

	localparam int STEPS = CNT_W / 2;
	localparam int REM_W = COORD_W + CNT_W;

	// returns {quotient bit, new remainder}
	function automatic logic [REM_W:0] div_bit(input logic [REM_W-1:0] r,
			input logic [COORD_W-1:0] d, input int sh);
		logic [REM_W-1:0] ds;
		begin
			ds = REM_W'(d) << sh;
			if (r >= ds) begin
				div_bit = {1'b1, r - ds};
			end else begin
				div_bit = {1'b0, r};
			end
		end
	endfunction

	logic [REM_W-1:0]   rem_s [0:STEPS];
	logic [COORD_W-1:0] den_s [0:STEPS];
	logic [CNT_W-1:0]   quo_s [0:STEPS];
	logic               neg_s [0:STEPS];
	logic               ovf_s [0:STEPS];

	// negative numerator floors below zero; too large a numerator saturates
	always_ff @(posedge clk) begin
		neg_s[0] <= num[NUM_W-1];
		ovf_s[0] <= !num[NUM_W-1] && (REM_W'(unsigned'(num)) >= {den, CNT_W'(0)});
		rem_s[0] <= REM_W'(unsigned'(num));
		den_s[0] <= den;
		quo_s[0] <= '0;
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [REM_W:0] t_hi;
		logic [REM_W:0] t_lo;
		assign t_hi = div_bit(rem_s[k], den_s[k], CNT_W - 1 - 2 * k);
		assign t_lo = div_bit(t_hi[REM_W-1:0], den_s[k], CNT_W - 2 - 2 * k);
		always_ff @(posedge clk) begin
			rem_s[k+1] <= t_lo[REM_W-1:0];
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= {quo_s[k][CNT_W-3:0], t_hi[REM_W], t_lo[REM_W]};
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (neg_s[STEPS]) begin
			quot <= '1;
		end else if (ovf_s[STEPS]) begin
			quot <= {1'b0, {CNT_W{1'b1}}};
		end else begin
			quot <= {1'b0, quo_s[STEPS]};
		end
	end

endmodule
`default_nettype wire

@@ rtl/slrc_vis.sv @@
// Closed segment against closed rectangle: box overlap plus line side test.
`timescale 1ns / 1ps
`default_nettype none
module slrc_vis
	import slrc_pkg::*;
(
	input  wire logic                      clk,
	input  wire rect_t                     rect,
	input  wire logic signed [COORD_W-1:0] x0,
	input  wire logic signed [COORD_W-1:0] y0,
	input  wire logic signed [COORD_W-1:0] sx,
	input  wire logic signed [COORD_W-1:0] sy,
	input  wire logic [CNT_W-1:0]          n,
	output logic                           vis
);

	localparam int D_W = COORD_W + 1;
	localparam int X_W = COORD_W + D_W;

	logic signed [PROD_W-1:0]  px_s1, py_s1;
	logic signed [D_W-1:0]     dxl_s1, dxh_s1, dyl_s1, dyh_s1;
	logic signed [COORD_W-1:0] sx_s1, sy_s1;
	logic                      rok_s1, nz_s1;

	always_ff @(posedge clk) begin
		px_s1  <= sx * signed'({1'b0, n});
		py_s1  <= sy * signed'({1'b0, n});
		dxl_s1 <= D_W'(rect.x_min) - D_W'(x0);
		dxh_s1 <= D_W'(rect.x_max) - D_W'(x0);
		dyl_s1 <= D_W'(rect.y_min) - D_W'(y0);
		dyh_s1 <= D_W'(rect.y_max) - D_W'(y0);
		sx_s1  <= sx;
		sy_s1  <= sy;
		rok_s1 <= (rect.x_min <= rect.x_max) && (rect.y_min <= rect.y_max);
		nz_s1  <= (n != '0);
	end

	logic signed [PROD_W-1:0] xhi, xlo, yhi, ylo;
	logic                     bbx, bby;
	assign xhi = (px_s1 > 0) ? px_s1 : '0;
	assign xlo = (px_s1 < 0) ? px_s1 : '0;
	assign yhi = (py_s1 > 0) ? py_s1 : '0;
	assign ylo = (py_s1 < 0) ? py_s1 : '0;
	assign bbx = (xhi >= PROD_W'(dxl_s1)) && (xlo <= PROD_W'(dxh_s1));
	assign bby = (yhi >= PROD_W'(dyl_s1)) && (ylo <= PROD_W'(dyh_s1));

	logic signed [X_W-1:0] p_xyl_s2, p_xyh_s2, p_yxl_s2, p_yxh_s2;
	logic                  ok_s2, nz_s2;

	always_ff @(posedge clk) begin
		p_xyl_s2 <= sx_s1 * dyl_s1;
		p_xyh_s2 <= sx_s1 * dyh_s1;
		p_yxl_s2 <= sy_s1 * dxl_s1;
		p_yxh_s2 <= sy_s1 * dxh_s1;
		ok_s2    <= rok_s1 && bbx && bby;
		nz_s2    <= nz_s1;
	end

	// side of each rectangle corner relative to the line
	logic signed [X_W:0] c [0:3];
	assign c[0] = (X_W+1)'(p_xyl_s2) - (X_W+1)'(p_yxl_s2);
	assign c[1] = (X_W+1)'(p_xyh_s2) - (X_W+1)'(p_yxl_s2);
	assign c[2] = (X_W+1)'(p_xyl_s2) - (X_W+1)'(p_yxh_s2);
	assign c[3] = (X_W+1)'(p_xyh_s2) - (X_W+1)'(p_yxh_s2);

	logic [3:0] pos_s3, neg_s3;
	logic       ok_s3, nz_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			pos_s3[i] <= (c[i] > 0);
			neg_s3[i] <= (c[i] < 0);
		end
		ok_s3 <= ok_s2;
		nz_s3 <= nz_s2;
	end

	always_ff @(posedge clk) begin
		vis <= ok_s3 && !(nz_s3 && ((&pos_s3) || (&neg_s3)));
	end

endmodule
`default_nettype wire

@@ rtl/stepped_line_rect_clip.sv @@
// Top level of the stepped line rectangle clipper.
//
// A line is P(j) = start + j*step for j = 0..step_count, in 16.16 fixed point.
// Raise start with the line fields; the transaction is taken when busy is low,
// and busy stays low, so a new line can be taken in every cycle.
// Each line gives one result: done is high for
// exactly one cycle with visible, first_step and last_step. visible tells
// whether the closed segment meets the closed clip rectangle; first_step and
// last_step bound the step indices whose points lie in the half-open
// rectangle. With no such step, first_step is step_count and last_step is 0.
// Latency is set by the four floor dividers, which resolve two quotient bits
// per stage; the visibility test runs alongside in four stages.
// The receiver cannot stall, so the pipeline never holds. The clip rectangle
// is written via the cfg channel (always ready); the user must write it only
// while no line is in flight (not enforced); unknown indexes are dropped.
// Reset clears the rectangle to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module stepped_line_rect_clip
	import slrc_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic signed [COORD_W-1:0] start_x,
	input  wire logic signed [COORD_W-1:0] start_y,
	input  wire logic signed [COORD_W-1:0] step_x,
	input  wire logic signed [COORD_W-1:0] step_y,
	input  wire logic [CNT_W-1:0]          step_count,
	output logic                           done,
	output logic                           visible,
	output logic [CNT_W-1:0]               first_step,
	output logic [CNT_W-1:0]               last_step,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [COORD_W-1:0]        cfg_data
);

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// clip rectangle registers
	rect_t rect_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_MIN: rect_q.x_min <= signed'(cfg_data);
				REG_Y_MIN: rect_q.y_min <= signed'(cfg_data);
				REG_X_MAX: rect_q.x_max <= signed'(cfg_data);
				REG_Y_MAX: rect_q.y_max <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// stage 1: capture the line
	logic                      acc;
	logic signed [COORD_W-1:0] x0_s1, y0_s1, sx_s1, sy_s1;
	logic [CNT_W-1:0]          n_s1;
	logic [DIV_LAT:0]          vld_s;

	assign acc = start && !busy;

	always_ff @(posedge clk) begin
		if (acc) begin
			x0_s1 <= start_x;
			y0_s1 <= start_y;
			sx_s1 <= step_x;
			sy_s1 <= step_y;
			n_s1  <= step_count;
		end
	end

	// valid bits travel alongside the data; the pipeline never holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[DIV_LAT-1:0], acc};
		end
	end

	// Turn each axis into two floor divisions by a positive divisor:
	// the low index is floor(nl/m)+1 and the high index floor(nh/m).
	typedef struct packed {
		logic signed [NUM_W-1:0] nl;
		logic signed [NUM_W-1:0] nh;
		logic [COORD_W-1:0]      m;
	} axis_t;

	function automatic axis_t axis_num(input logic signed [COORD_W-1:0] p,
			input logic signed [COORD_W-1:0] s,
			input logic signed [COORD_W-1:0] lo,
			input logic signed [COORD_W-1:0] hi);
		axis_t a;
		begin
			if (!s[COORD_W-1]) begin
				a.nl = NUM_W'(lo) - NUM_W'(p) - NUM_W'(1);
				a.nh = NUM_W'(hi) - NUM_W'(p) - NUM_W'(1);
				a.m  = s;
			end else begin
				a.nl = NUM_W'(p) - NUM_W'(hi);
				a.nh = NUM_W'(p) - NUM_W'(lo);
				a.m  = COORD_W'(-s);
			end
			axis_num = a;
		end
	endfunction

	axis_t ax, ay;
	assign ax = axis_num(x0_s1, sx_s1, rect_q.x_min, rect_q.x_max);
	assign ay = axis_num(y0_s1, sy_s1, rect_q.y_min, rect_q.y_max);

	logic signed [CNT_W:0] fxl, fxh, fyl, fyh;

	slrc_div u_div_xl (.clk(clk), .num(ax.nl), .den(ax.m), .quot(fxl));
	slrc_div u_div_xh (.clk(clk), .num(ax.nh), .den(ax.m), .quot(fxh));
	slrc_div u_div_yl (.clk(clk), .num(ay.nl), .den(ay.m), .quot(fyl));
	slrc_div u_div_yh (.clk(clk), .num(ay.nh), .den(ay.m), .quot(fyh));

	logic vis_raw;

	slrc_vis u_vis (
		.clk (clk),
		.rect(rect_q),
		.x0  (x0_s1),
		.y0  (y0_s1),
		.sx  (sx_s1),
		.sy  (sy_s1),
		.n   (n_s1),
		.vis (vis_raw)
	);

	// side data delayed to meet the divider results
	typedef struct packed {
		logic             zx;
		logic             inx;
		logic             zy;
		logic             iny;
		logic [CNT_W-1:0] n;
	} side_t;

	side_t side_s [0:DIV_LAT];
	logic  vis_s  [VIS_LAT:DIV_LAT];

	always_comb begin
		side_s[0].zx  = (sx_s1 == '0);
		side_s[0].inx = (rect_q.x_min <= x0_s1) && (x0_s1 < rect_q.x_max);
		side_s[0].zy  = (sy_s1 == '0);
		side_s[0].iny = (rect_q.y_min <= y0_s1) && (y0_s1 < rect_q.y_max);
		side_s[0].n   = n_s1;
	end

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
		end
	end

	assign vis_s[VIS_LAT] = vis_raw;

	for (genvar k = VIS_LAT; k < DIV_LAT; k++) begin : g_vis
		always_ff @(posedge clk) begin
			vis_s[k+1] <= vis_s[k];
		end
	end

	// combine the axis ranges and clamp to 0 .. step_count
	side_t               sd;
	logic signed [J_W-1:0] jlx, jhx, jly, jhy, jl, jh, nj;
	logic                  empty;

	assign sd = side_s[DIV_LAT];
	assign nj = J_W'(signed'({1'b0, sd.n}));

	always_comb begin
		if (sd.zx) begin
			jlx = sd.inx ? J_W'(0) : J_W'(1);
			jhx = sd.inx ? J_W'({1'b0, {CNT_W{1'b1}}}) : J_W'(0);
		end else begin
			jlx = J_W'(fxl) + J_W'(1);
			jhx = J_W'(fxh);
		end
		if (sd.zy) begin
			jly = sd.iny ? J_W'(0) : J_W'(1);
			jhy = sd.iny ? J_W'({1'b0, {CNT_W{1'b1}}}) : J_W'(0);
		end else begin
			jly = J_W'(fyl) + J_W'(1);
			jhy = J_W'(fyh);
		end
		jl = (jlx > jly) ? jlx : jly;
		if (jl < 0) begin
			jl = '0;
		end
		jh = (jhx < jhy) ? jhx : jhy;
		if (jh > nj) begin
			jh = nj;
		end
		empty = (jl > jh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[DIV_LAT];
		end
	end

	always_ff @(posedge clk) begin
		visible    <= vis_s[DIV_LAT];
		first_step <= empty ? sd.n : jl[CNT_W-1:0];
		last_step  <= empty ? '0 : jh[CNT_W-1:0];
	end

`ifndef NO_ASSERTIONS
	// a segment that misses the rectangle cannot hold an inside step
	a_hidden_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && !visible |-> last_step == '0)
		else $error("hidden line reports an inside step");

	// a non-empty step range is ordered
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && last_step != '0 |-> first_step <= last_step)
		else $error("step range out of order");

	// one result for every line taken, after a fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> ##(DIV_LAT+1) done)
		else $error("result missing after pipeline latency");
`endif

endmodule
`default_nettype wire
